### rtl/core/rpwc_pkg.sv
`timescale 1ns / 1ps

package rpwc_pkg;

  localparam int unsigned NumChannels = 6;

  localparam int unsigned ChW      = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned WidthW   = 16;
  localparam int unsigned StickW   = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Stick thresholds of the arm gesture.
  localparam logic signed [StickW-1:0] ArmLow  = -11'sd950;
  localparam logic signed [StickW-1:0] ArmHigh = 11'sd950;

  typedef struct packed {
    logic              start;
    logic [WidthW-1:0] width;
    logic [WidthW-1:0] pmin;
    logic [WidthW-1:0] pmax;
  } map_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [StickW-1:0] value;
  } map_rsp_t;

  typedef struct packed {
    logic              en;
    logic [ChW-1:0]    ch;
    logic [WidthW-1:0] time_lo;
  } rise_wr_t;

  typedef struct packed {
    logic                     en;
    logic [ChW-1:0]           ch;
    logic signed [StickW-1:0] value;
  } stick_wr_t;

endpackage

### rtl/core/rpwc_map.sv
`timescale 1ns / 1ps

module rpwc_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpwc_pkg::map_req_t req_i,
  output rpwc_pkg::map_rsp_t rsp_o
);
  import rpwc_pkg::*;

  localparam int unsigned CalcW    = 30;
  localparam int unsigned QuotW    = 10;
  localparam int unsigned DivSteps = 10;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [CalcW-1:0] ScaleSpan = CalcW'(2000);
  localparam logic [CalcW-1:0] ScaleHalf = CalcW'(1000);
  localparam logic [QuotW-1:0] QuotSat   = QuotW'(1000);
  localparam logic [CntW-1:0]  CntLast   = CntW'(DivSteps - 1);

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_NUM,
    M_CMP,
    M_DIV,
    M_SIGN
  } map_state_e;

  map_state_e state_q;
  logic                     done_q;
  logic signed [StickW-1:0] value_q;

  logic [WidthW-1:0]       width_q;
  logic [WidthW-1:0]       pmin_q;
  logic [WidthW-1:0]       d_q;
  logic                    empty_q;
  logic signed [CalcW-1:0] prod_q;
  logic [CalcW-1:0]        dk_q;
  logic                    neg_q;
  logic [CalcW-1:0]        rem_q;
  logic [CalcW-1:0]        div_q;
  logic [QuotW-1:0]        quot_q;
  logic [CntW-1:0]         cnt_q;

  logic [WidthW:0]          span;
  logic signed [WidthW:0]   offs;
  logic signed [CalcW-1:0]  offs_ext;
  logic signed [CalcW-1:0]  num;
  logic [CalcW-1:0]         mag;
  logic [CalcW:0]           sub;
  logic                     ge;
  logic signed [StickW-1:0] quot_ext;
  logic signed [StickW-1:0] value_d;

  assign span     = {1'b0, req_i.pmax} - {1'b0, req_i.pmin};
  assign offs     = $signed({1'b0, width_q}) - $signed({1'b0, pmin_q});
  assign offs_ext = CalcW'(offs);
  assign num      = prod_q - $signed(dk_q);
  assign mag      = num[CalcW-1] ? CalcW'(-num) : CalcW'(num);

  // The one compare-subtract unit: it checks for saturation once, then
  // produces one quotient bit per cycle.
  assign sub = {1'b0, rem_q} - {1'b0, div_q};
  assign ge  = ~sub[CalcW];

  assign quot_ext = $signed({1'b0, quot_q});
  always_comb begin
    if (empty_q) begin
      value_d = '0;
    end else if (neg_q) begin
      value_d = -quot_ext;
    end else begin
      value_d = quot_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      value_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            state_q <= M_MUL;
          end
        end
        M_MUL: state_q <= M_NUM;
        M_NUM: state_q <= M_CMP;
        M_CMP: begin
          state_q <= ge ? M_SIGN : M_DIV;
        end
        M_DIV: begin
          if (cnt_q == '0) begin
            state_q <= M_SIGN;
          end
        end
        M_SIGN: begin
          value_q <= value_d;
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          width_q <= req_i.width;
          pmin_q  <= req_i.pmin;
          d_q     <= span[WidthW-1:0];
          empty_q <= (req_i.pmax <= req_i.pmin);
        end
      end
      M_MUL: begin
        prod_q <= offs_ext * $signed(ScaleSpan);
        dk_q   <= CalcW'(d_q) * ScaleHalf;
      end
      M_NUM: begin
        neg_q <= num[CalcW-1];
        rem_q <= mag;
        div_q <= dk_q;
      end
      M_CMP: begin
        if (ge) begin
          // At least a thousand times the span: clamp to full scale.
          quot_q <= QuotSat;
        end else begin
          quot_q <= '0;
          div_q  <= CalcW'(d_q) << (DivSteps - 1);
          cnt_q  <= CntLast;
        end
      end
      M_DIV: begin
        if (ge) begin
          rem_q <= sub[CalcW-1:0];
        end
        quot_q <= {quot_q[QuotW-2:0], ge};
        div_q  <= div_q >> 1;
        cnt_q  <= cnt_q - CntW'(1);
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = value_q;

endmodule

### rtl/core/rpwc_store.sv
`timescale 1ns / 1ps

module rpwc_store #(
  parameter int unsigned NUM_CHANNELS = rpwc_pkg::NumChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpwc_pkg::rise_wr_t            rise_wr_i,
  input  logic [rpwc_pkg::ChW-1:0]      rise_ch_i,
  output logic [rpwc_pkg::WidthW-1:0]   rise_o,
  input  rpwc_pkg::stick_wr_t           stick_wr_i,
  input  logic [rpwc_pkg::ChW-1:0]      thr_ch_i,
  input  logic [rpwc_pkg::ChW-1:0]      yaw_ch_i,
  output logic                          arm_o
);
  import rpwc_pkg::*;

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Only the low half of a rise time matters, since widths wrap at 16 bits.
  // Each channel keeps its stick value only as the two gesture flags.
  logic [WidthW-1:0]       rise_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] low_q;
  logic [NUM_CHANNELS-1:0] high_q;

  logic [IdxW-1:0] rise_wr_idx;
  logic [IdxW-1:0] rise_rd_idx;
  logic [IdxW-1:0] stick_idx;
  logic [IdxW-1:0] thr_idx;
  logic [IdxW-1:0] yaw_idx;
  logic            thr_ok;
  logic            yaw_ok;
  logic            thr_low;
  logic            yaw_high;

  assign rise_wr_idx = IdxW'(rise_wr_i.ch);
  assign rise_rd_idx = IdxW'(rise_ch_i);
  assign stick_idx   = IdxW'(stick_wr_i.ch);
  assign thr_idx     = IdxW'(thr_ch_i);
  assign yaw_idx     = IdxW'(yaw_ch_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_q[i] <= '0;
      end
      // Every channel starts at full negative stick.
      low_q  <= '1;
      high_q <= '0;
    end else begin
      if (rise_wr_i.en) begin
        rise_q[rise_wr_idx] <= rise_wr_i.time_lo;
      end
      if (stick_wr_i.en) begin
        low_q[stick_idx]  <= (stick_wr_i.value < ArmLow);
        high_q[stick_idx] <= (stick_wr_i.value > ArmHigh);
      end
    end
  end

  assign rise_o = rise_q[rise_rd_idx];

  // A gesture channel outside the array reads as full negative stick.
  assign thr_ok   = (int'(thr_ch_i) < NUM_CHANNELS);
  assign yaw_ok   = (int'(yaw_ch_i) < NUM_CHANNELS);
  assign thr_low  = thr_ok ? low_q[thr_idx] : 1'b1;
  assign yaw_high = yaw_ok ? high_q[yaw_idx] : 1'b0;
  assign arm_o    = thr_low & yaw_high;

endmodule

### rtl/core/rc_pulse_width_capture_top.sv
`timescale 1ns / 1ps

// Measures servo pulses on up to NUM_CHANNELS receiver pins, one pin edge per
// item. A rising edge, or any edge on a channel number at or above
// NUM_CHANNELS, is taken without stalling the input. A falling edge on a real
// channel yields one result item through the width, map, store and emit
// steps; the block stalls its input meanwhile and returns to ready in the
// cycle after the result is loaded, later if the output is still stalled.
// The mapper's divider retires one quotient bit per cycle over ten bits; it
// is skipped when the width lies at or beyond either end of the pulse range
// and the stick value clamps. Configuration writes are taken in any cycle and
// belong only to idle periods.
module rc_pulse_width_capture_top #(
  parameter int unsigned NUM_CHANNELS = rpwc_pkg::NumChannels
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rpwc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rpwc_pkg::CfgDataW-1:0]      cfg_data_i,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rpwc_pkg::ChW-1:0]           channel_i,
  input  logic                               level_i,
  input  logic [rpwc_pkg::TimeW-1:0]         time_us_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rpwc_pkg::ChW-1:0]           out_channel_o,
  output logic [rpwc_pkg::WidthW-1:0]        pulse_width_o,
  output logic signed [rpwc_pkg::StickW-1:0] stick_value_o,
  output logic                               arm_gesture_o
);
  import rpwc_pkg::*;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_MIN = 3'd0,
    CFG_PULSE_MAX = 3'd1,
    CFG_THR_CH    = 3'd2,
    CFG_YAW_CH    = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIDTH,
    ST_MAP,
    ST_STORE,
    ST_EMIT
  } top_state_e;

  logic [WidthW-1:0] pulse_min_q;
  logic [WidthW-1:0] pulse_max_q;
  logic [ChW-1:0]    thr_ch_q;
  logic [ChW-1:0]    yaw_ch_q;

  top_state_e               state_q;
  logic                     start_q;
  logic                     out_valid_q;
  logic [ChW-1:0]           out_channel_q;
  logic [WidthW-1:0]        out_width_q;
  logic signed [StickW-1:0] out_stick_q;
  logic                     out_arm_q;

  logic [ChW-1:0]           ch_q;
  logic [WidthW-1:0]        time_lo_q;
  logic [WidthW-1:0]        width_q;
  logic signed [StickW-1:0] stick_q;

  logic      in_take;
  logic      ch_ok;
  logic      out_load;
  logic [WidthW-1:0] rise_rd;
  logic      arm;
  map_req_t  map_req;
  map_rsp_t  map_rsp;
  rise_wr_t  rise_wr;
  stick_wr_t stick_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_min_q <= WidthW'(1010);
      pulse_max_q <= WidthW'(2000);
      thr_ch_q    <= ChW'(2);
      yaw_ch_q    <= ChW'(3);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PULSE_MIN: pulse_min_q <= cfg_data_i;
        CFG_PULSE_MAX: pulse_max_q <= cfg_data_i;
        CFG_THR_CH:    thr_ch_q    <= cfg_data_i[ChW-1:0];
        CFG_YAW_CH:    yaw_ch_q    <= cfg_data_i[ChW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign ch_ok      = (int'(channel_i) < NUM_CHANNELS);
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      start_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      out_channel_q <= '0;
      out_width_q   <= '0;
      out_stick_q   <= '0;
      out_arm_q     <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_load) begin
        out_valid_q   <= 1'b1;
        out_channel_q <= ch_q;
        out_width_q   <= width_q;
        out_stick_q   <= stick_q;
        out_arm_q     <= arm;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take && ch_ok && !level_i) begin
            state_q <= ST_WIDTH;
          end
        end
        ST_WIDTH: begin
          start_q <= 1'b1;
          state_q <= ST_MAP;
        end
        ST_MAP: begin
          if (map_rsp.done) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q      <= channel_i;
      time_lo_q <= time_us_i[WidthW-1:0];
    end
    if (state_q == ST_WIDTH) begin
      width_q <= time_lo_q - rise_rd;
    end
    if (state_q == ST_MAP && map_rsp.done) begin
      stick_q <= map_rsp.value;
    end
  end

  assign rise_wr.en      = in_take && ch_ok && level_i;
  assign rise_wr.ch      = channel_i;
  assign rise_wr.time_lo = time_us_i[WidthW-1:0];

  // The gesture is read after this pulse's value is stored, when the result item is loaded.
  assign stick_wr.en    = (state_q == ST_STORE);
  assign stick_wr.ch    = ch_q;
  assign stick_wr.value = stick_q;

  assign map_req.start = start_q;
  assign map_req.width = width_q;
  assign map_req.pmin  = pulse_min_q;
  assign map_req.pmax  = pulse_max_q;

  rpwc_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  rpwc_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rise_wr_i  (rise_wr),
    .rise_ch_i  (ch_q),
    .rise_o     (rise_rd),
    .stick_wr_i (stick_wr),
    .thr_ch_i   (thr_ch_q),
    .yaw_ch_i   (yaw_ch_q),
    .arm_o      (arm)
  );

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign pulse_width_o = out_width_q;
  assign stick_value_o = out_stick_q;
  assign arm_gesture_o = out_arm_q;

endmodule

### rtl/core/rpwc_checker.sv
`timescale 1ns / 1ps

module rpwc_checker #(
  parameter int unsigned NUM_CHANNELS = rpwc_pkg::NumChannels
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [rpwc_pkg::ChW-1:0]           channel_i,
  input logic                               level_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [rpwc_pkg::ChW-1:0]           out_channel_o,
  input logic [rpwc_pkg::WidthW-1:0]        pulse_width_o,
  input logic signed [rpwc_pkg::StickW-1:0] stick_value_o,
  input logic                               arm_gesture_o
);
  import rpwc_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A falling edge on a real channel starts a measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !level_i && (int'(channel_i) < NUM_CHANNELS) |=> in_stall_o)
    else $error("falling edge did not start a measurement");

  // A rising edge only records a time and leaves the block ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && level_i |=> !in_stall_o)
    else $error("rising edge left the input stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stick_value_o >= -11'sd1000) && (stick_value_o <= 11'sd1000))
    else $error("stick value outside the clamp range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_channel_o)
      && $stable(pulse_width_o) && $stable(stick_value_o) && $stable(arm_gesture_o))
    else $error("stalled result item changed");

endmodule

bind rc_pulse_width_capture_top rpwc_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_rpwc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .channel_i     (channel_i),
  .level_i       (level_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_channel_o (out_channel_o),
  .pulse_width_o (pulse_width_o),
  .stick_value_o (stick_value_o),
  .arm_gesture_o (arm_gesture_o)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rpwc_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned HoldAt      = 60;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned MaxGap      = 8;
  localparam int unsigned MaxChCode   = (2 ** ChW) - 1;
  localparam int unsigned TimeoutNs   = 5_000_000;

  localparam logic [WidthW-1:0] ResetPulseMin = 16'd1010;
  localparam logic [WidthW-1:0] ResetPulseMax = 16'd2000;
  localparam logic [ChW-1:0]    ResetThrottle = 3'd2;
  localparam logic [ChW-1:0]    ResetYaw      = 3'd3;

  localparam logic signed [StickW-1:0] StickLow = -11'sd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PULSE_MIN   = 3'd0,
    REG_PULSE_MAX   = 3'd1,
    REG_THROTTLE_CH = 3'd2,
    REG_YAW_CH      = 3'd3
  } reg_index_e;

  // First index past the register file; writes there must be ignored.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd4;

  typedef enum logic {
    LVL_FALL = 1'b0,
    LVL_RISE = 1'b1
  } level_e;

  typedef enum logic {
    OP_EDGE,
    OP_REG_WRITE
  } op_kind_e;

  typedef struct {
    op_kind_e            kind;
    logic [ChW-1:0]      channel;
    logic                level;
    logic [TimeW-1:0]    time_us;
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] reg_data;
    int unsigned         gap;
  } bench_op_t;

  typedef struct packed {
    logic [ChW-1:0]           channel;
    logic [WidthW-1:0]        width;
    logic signed [StickW-1:0] stick;
    logic                     arm;
  } capture_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [ChW-1:0]            channel_i   = '0;
  logic                      level_i     = 1'b0;
  logic [TimeW-1:0]          time_us_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [ChW-1:0]            out_channel_o;
  logic [WidthW-1:0]         pulse_width_o;
  logic signed [StickW-1:0]  stick_value_o;
  logic                      arm_gesture_o;

  rc_pulse_width_capture_top #(
    .NUM_CHANNELS(NumChannels)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .level_i       (level_i),
    .time_us_i     (time_us_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .pulse_width_o (pulse_width_o),
    .stick_value_o (stick_value_o),
    .arm_gesture_o (arm_gesture_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  bench_op_t pending_ops[$];
  capture_t  captures_due[$];

  // Shadow of the capture state and registers, updated at each accepted item.
  logic [TimeW-1:0]         rise_stamp [NumChannels];
  logic signed [StickW-1:0] held_stick [NumChannels];
  logic [WidthW-1:0]        pmin_q;
  logic [WidthW-1:0]        pmax_q;
  logic [ChW-1:0]           throttle_q;
  logic [ChW-1:0]           yaw_q;

  int unsigned gap_left;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned results_seen;
  int unsigned mismatch_count = 0;

  function automatic logic signed [StickW-1:0] scale_width(logic [WidthW-1:0] w);
    longint lo, hi, ww, span, val;
    lo = pmin_q;
    hi = pmax_q;
    ww = w;
    if (hi <= lo) return '0;
    span = hi - lo;
    val  = ((ww - lo) * 2000 - 1000 * span) / span;
    if (val > 1000) val = 1000;
    if (val < -1000) val = -1000;
    return val[StickW-1:0];
  endfunction

  function automatic logic signed [StickW-1:0] stick_of(logic [ChW-1:0] ch);
    if (ch >= NumChannels) return StickLow;
    return held_stick[ch];
  endfunction

  task automatic capture_edge(logic [ChW-1:0] ch, logic lvl, logic [TimeW-1:0] t);
    capture_t         cap;
    logic [TimeW-1:0] diff;
    if (ch >= NumChannels) return;
    if (lvl == LVL_RISE) begin
      rise_stamp[ch] = t;
      return;
    end
    diff           = t - rise_stamp[ch];
    cap.channel    = ch;
    cap.width      = diff[WidthW-1:0];
    cap.stick      = scale_width(cap.width);
    held_stick[ch] = cap.stick;
    // The gesture reads the stored values after this pulse has been stored.
    cap.arm = (stick_of(throttle_q) < ArmLow) && (stick_of(yaw_q) > ArmHigh);
    captures_due.push_back(cap);
  endtask

  task automatic write_shadow(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_PULSE_MIN:   pmin_q = data;
      REG_PULSE_MAX:   pmax_q = data;
      REG_THROTTLE_CH: throttle_q = data[ChW-1:0];
      REG_YAW_CH:      yaw_q = data[ChW-1:0];
      default: ;
    endcase
  endtask

  // Driver: edges go out as soon as their gap has passed, register writes only
  // once the block has been quiet for a while.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic      in_fire;
    logic      cfg_fire;
    logic      in_next;
    logic      cfg_next;
    bench_op_t op;
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        rise_stamp[i] = '0;
        held_stick[i] = StickLow;
      end
      pmin_q       = ResetPulseMin;
      pmax_q       = ResetPulseMax;
      throttle_q   = ResetThrottle;
      yaw_q        = ResetYaw;
      gap_left     = 0;
      quiet_cycles = 0;
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      in_fire  = in_valid_i && !in_stall_o;
      cfg_fire = cfg_valid_i && cfg_ready_o;
      if (in_fire) begin
        capture_edge(channel_i, level_i, time_us_i);
        gap_left = (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
      end
      if (cfg_fire) write_shadow(cfg_index_i, cfg_data_i);
      if (captures_due.size() == 0 && !in_valid_i && !out_valid_o) quiet_cycles++;
      else quiet_cycles = 0;

      in_next  = in_valid_i && !in_fire;
      cfg_next = cfg_valid_i && !cfg_fire;
      if (!in_next && !cfg_next && pending_ops.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_ops[0].kind == OP_EDGE) begin
          op = pending_ops.pop_front();
          channel_i <= op.channel;
          level_i   <= op.level;
          time_us_i <= op.time_us;
          in_next = 1'b1;
        end else if (quiet_cycles >= DrainCycles) begin
          op = pending_ops.pop_front();
          cfg_index_i <= op.reg_index;
          cfg_data_i  <= op.reg_data;
          cfg_next = 1'b1;
        end
      end
      in_valid_i  <= in_next;
      cfg_valid_i <= cfg_next;
    end
  end

  // Monitor: checks each accepted result item and paces the output stall.
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    capture_t want;
    logic     stall_next;
    if (!rst_ni) begin
      stall_left   = 0;
      hold_left    = 0;
      results_seen = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (captures_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("unexpected result: ch %0d width %0d stick %0d arm %0b",
                     out_channel_o, pulse_width_o, stick_value_o, arm_gesture_o);
        end else begin
          want = captures_due.pop_front();
          if (out_channel_o !== want.channel || pulse_width_o !== want.width ||
              stick_value_o !== want.stick || arm_gesture_o !== want.arm) begin
            mismatch_count++;
            if (mismatch_count <= ReportMax)
              $display("mismatch: expected ch %0d width %0d stick %0d arm %0b,",
                       want.channel, want.width, want.stick, want.arm,
                       " got ch %0d width %0d stick %0d arm %0b",
                       out_channel_o, pulse_width_o, stick_value_o, arm_gesture_o);
          end
        end
        results_seen++;
        stall_left = ((results_seen % 200) < 40) ? 0 : $urandom_range(0, MaxGap);
        // One long hold-off lets the block back up and stall its input.
        if (results_seen == HoldAt) hold_left = LongHold;
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = (stall_left != 0);
      end
      out_stall_i <= stall_next;
    end
  end

  // Stimulus generation keeps its own view of open pulses and the pulse range.
  logic             open_pulse [NumChannels];
  logic [TimeW-1:0] open_rise  [NumChannels];
  int unsigned      gen_min;
  int unsigned      gen_max;

  task automatic add_edge(logic [ChW-1:0] ch, logic lvl, logic [TimeW-1:0] t,
                          int unsigned gap);
    bench_op_t op;
    op.kind      = OP_EDGE;
    op.channel   = ch;
    op.level     = lvl;
    op.time_us   = t;
    op.reg_index = '0;
    op.reg_data  = '0;
    op.gap       = gap;
    pending_ops.push_back(op);
  endtask

  task automatic add_pulse(logic [ChW-1:0] ch, logic [TimeW-1:0] t, logic [TimeW-1:0] w);
    add_edge(ch, LVL_RISE, t, $urandom_range(0, MaxGap));
    add_edge(ch, LVL_FALL, t + w, $urandom_range(0, MaxGap));
  endtask

  task automatic add_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    bench_op_t op;
    op.kind      = OP_REG_WRITE;
    op.channel   = '0;
    op.level     = 1'b0;
    op.time_us   = '0;
    op.reg_index = idx;
    op.reg_data  = data;
    op.gap       = 0;
    pending_ops.push_back(op);
    if (idx == REG_PULSE_MIN) gen_min = data;
    if (idx == REG_PULSE_MAX) gen_max = data;
  endtask

  // Widths cluster at both ends of the range so that both clamps and the arm
  // gesture come up often; some are wild or span more than 16 bits of time.
  function automatic logic [TimeW-1:0] pick_width();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:    return gen_min + $urandom_range(0, 40) - 20;
      2, 3:    return gen_max + $urandom_range(0, 40) - 20;
      4:       return $urandom_range(0, 65535);
      5:       return $urandom;
      default: return (gen_max > gen_min) ? $urandom_range(gen_min, gen_max)
                                          : $urandom_range(0, 4000);
    endcase
  endfunction

  task automatic add_random_phase(int unsigned n_items);
    int unsigned      placed;
    int unsigned      sel;
    int unsigned      gap;
    int unsigned      ch;
    logic             lvl;
    logic [TimeW-1:0] t;
    placed = 0;
    while (placed < n_items) begin
      sel = $urandom_range(0, 99);
      gap = ((placed % 60) < 15) ? 0 : $urandom_range(0, MaxGap);
      ch  = $urandom_range(0, NumChannels - 1);
      t   = $urandom;
      if (sel < 5) begin
        // Edges on channels past the last one are dropped by the block.
        add_edge($urandom_range(NumChannels, MaxChCode), $urandom_range(0, 1), t, gap);
      end else if (sel < 12) begin
        lvl = $urandom_range(0, 1);
        add_edge(ch, lvl, t, gap);
        open_pulse[ch] = lvl;
        open_rise[ch]  = t;
        placed++;
      end else if (!open_pulse[ch]) begin
        add_edge(ch, LVL_RISE, t, gap);
        open_pulse[ch] = 1'b1;
        open_rise[ch]  = t;
        placed++;
      end else begin
        add_edge(ch, LVL_FALL, open_rise[ch] + pick_width(), gap);
        open_pulse[ch] = 1'b0;
        placed++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         thr;
    int unsigned         yaw;
    logic [CfgDataW-1:0] data;
    for (int i = 0; i < NumChannels; i++) begin
      open_pulse[i] = 1'b0;
      open_rise[i]  = '0;
    end
    gen_min = ResetPulseMin;
    gen_max = ResetPulseMax;

    // A falling edge with no rising edge measures from the reset rise time.
    add_edge(3'd0, LVL_FALL, 32'd1500, $urandom_range(0, MaxGap));
    add_pulse(3'd2, 32'h0000_1000, 32'd1010);
    // Exactly the maximum with a wrapping timestamp; throttle is low, so this arms.
    add_pulse(3'd3, 32'hFFFF_FC00, 32'd2000);
    add_pulse(3'd1, 32'hFFFF_FFFF, 32'd0);
    add_pulse(3'd4, 32'd0, 32'd65535);
    // A second rising edge replaces the first one's timestamp.
    add_edge(3'd5, LVL_RISE, 32'd100, $urandom_range(0, MaxGap));
    add_pulse(3'd5, 32'd200, 32'd1505);
    add_edge(3'd6, LVL_RISE, 32'hA5A5_A5A5, $urandom_range(0, MaxGap));
    add_edge(3'd7, LVL_FALL, 32'h5A5A_5A5A, $urandom_range(0, MaxGap));
    // High time longer than 16 bits of microseconds wraps.
    add_pulse(3'd0, 32'd5, 32'd66736);
    add_pulse(3'd1, 32'd10, 32'd1011);

    // Empty pulse range, equal and then reversed.
    add_reg_write(REG_PULSE_MIN, 16'd1500);
    add_reg_write(REG_PULSE_MAX, 16'd1500);
    add_pulse(3'd0, $urandom, 32'd1700);
    add_reg_write(REG_PULSE_MAX, 16'd1000);
    add_pulse(3'd4, $urandom, 32'd1200);
    // Full range, and a throttle channel past the last channel.
    add_reg_write(REG_PULSE_MIN, 16'd0);
    add_reg_write(REG_PULSE_MAX, 16'hFFFF);
    add_reg_write(REG_THROTTLE_CH, 16'hFFFF);
    add_pulse(3'd3, $urandom, 32'd65535);
    add_pulse(3'd3, $urandom, 32'd0);
    add_reg_write(RegUnused + 3'd1, 16'h1234);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin lo = 1000; hi = 2000; end
        1: begin lo = 0;    hi = 65535; end
        2: begin lo = 1500; hi = 1503; end
        3: begin lo = 2000; hi = 1000; end
        default: begin
          lo = $urandom_range(500, 1500);
          hi = lo + $urandom_range(200, 1500);
        end
      endcase
      thr = $urandom_range(0, NumChannels - 1);
      yaw = (thr + $urandom_range(1, NumChannels - 1)) % NumChannels;
      if (p == 4) yaw = NumChannels;
      add_reg_write(REG_PULSE_MIN, lo);
      add_reg_write(REG_PULSE_MAX, hi);
      data = $urandom;
      data[ChW-1:0] = thr;
      add_reg_write(REG_THROTTLE_CH, data);
      data = $urandom;
      data[ChW-1:0] = yaw;
      add_reg_write(REG_YAW_CH, data);
      add_reg_write(RegUnused + (p % 4), $urandom);
      add_random_phase(PhaseItems);
    end
    // Leave the block at its reset settings again.
    add_reg_write(REG_PULSE_MIN, ResetPulseMin);
    add_reg_write(REG_PULSE_MAX, ResetPulseMax);
    add_reg_write(REG_THROTTLE_CH, ResetThrottle);
    add_reg_write(REG_YAW_CH, ResetYaw);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid_i || cfg_valid_i || captures_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && captures_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("FAIL");
    $finish;
  end

endmodule
